FILE: rtl/sparse_run_length_encoder_unit_defines.svh
// ----------------------------------------------------------------------------
// sparse run-length encoder - assertion macros
// shared concurrent assertion forms, sampled on the rising clock edge and
// switched off while the active-low reset is held
// ----------------------------------------------------------------------------
`ifndef SPARSE_RUN_LENGTH_ENCODER_UNIT_DEFINES_SVH
`define SPARSE_RUN_LENGTH_ENCODER_UNIT_DEFINES_SVH

// consequent holds in the same cycle as the antecedent
`define SRE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sre assertion failed");

// consequent holds in the cycle after the antecedent
`define SRE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sre assertion failed");

`endif

FILE: rtl/sre_pkg.sv
// ----------------------------------------------------------------------------
// sre_pkg
// types, constants and helper functions of the sparse run-length encoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sre_pkg;

    localparam int BUF_WORDS   = 65536;
    localparam int MAX_RESULTS = 4;
    localparam int ADDR_W      = 16;
    localparam int WORD_W      = 32;
    localparam int LEN_W       = 16;
    localparam int TOTAL_W     = 17;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int IDX_W       = $clog2(MAX_RESULTS);

    // full-width address space with one carry bit for header + 1
    localparam logic [WORD_W:0]    BUF_LIMIT   = (WORD_W + 1)'(BUF_WORDS);
    localparam logic [TOTAL_W-1:0] TOTAL_LIMIT = TOTAL_W'(BUF_WORDS);

    typedef enum logic [1:0] {
        REQ_START     = 2'd0,
        REQ_SAMPLE    = 2'd1,
        REQ_EMPTY_RUN = 2'd2,
        REQ_END       = 2'd3
    } t_req;

    typedef struct packed {
        logic               in_empty_run;
        logic [WORD_W-1:0]  run_count;
        logic [WORD_W-1:0]  header_addr;
        logic [WORD_W-1:0]  next_addr;
    } t_state;

    localparam t_state STATE_RESET = '{
        in_empty_run: 1'b1,
        run_count:    '0,
        header_addr:  WORD_W'(1),
        next_addr:    WORD_W'(3)
    };

    typedef struct packed {
        logic [TOTAL_W-1:0] total_words;
        logic               overflow;
        logic               write_valid;
        logic [WORD_W-1:0]  write_data;
        logic [ADDR_W-1:0]  write_addr;
    } t_result;

    typedef struct packed {
        logic [CNT_W-1:0]                count;
        t_result [MAX_RESULTS-1:0]       res;
    } t_batch;

    function automatic logic is_nan(input logic [WORD_W-1:0] b);
        return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    endfunction

    // +0 and -0 compare equal, a NaN never does
    function automatic logic float_eq(input logic [WORD_W-1:0] a,
                                      input logic [WORD_W-1:0] b);
        logic both_zero;
        both_zero = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
        return !is_nan(a) && !is_nan(b) && (both_zero || (a == b));
    endfunction

    function automatic logic [WORD_W-1:0] sat_add(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b);
        logic [WORD_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[WORD_W] ? {WORD_W{1'b1}} : sum[WORD_W-1:0];
    endfunction

    function automatic t_result make_result(input logic [WORD_W:0]    addr,
                                            input logic [WORD_W-1:0]  data,
                                            input logic [TOTAL_W-1:0] total);
        t_result r;
        r.overflow    = (addr >= BUF_LIMIT);
        r.write_valid = !r.overflow;
        r.write_addr  = addr[ADDR_W-1:0];
        r.write_data  = data;
        r.total_words = total;
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/sre_step_logic.sv
// ----------------------------------------------------------------------------
// sre_step_logic
// combinational step: from the current state and one request, the next
// state and the list of memory-write results it causes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sre_step_logic (
    input  sre_pkg::t_state               i_state,
    input  logic [sre_pkg::WORD_W-1:0]    i_empty_value,
    input  sre_pkg::t_req                 i_req,
    input  logic [sre_pkg::WORD_W-1:0]    i_sample,
    input  logic [sre_pkg::LEN_W-1:0]     i_run_length,
    output sre_pkg::t_state               o_state,
    output sre_pkg::t_batch               o_batch
);
    import sre_pkg::*;

    logic                is_match;
    logic                closing;
    logic                opening;
    logic [WORD_W-1:0]   rc_base;
    logic [WORD_W-1:0]   rc_inc;
    logic [WORD_W-1:0]   rc_next;
    logic [WORD_W-1:0]   next_p1;
    logic [WORD_W-1:0]   next_p2;
    logic [WORD_W:0]     hdr_ext;
    logic [WORD_W:0]     hdr_p1;
    logic [WORD_W:0]     nx_ext;
    logic [TOTAL_W-1:0]  total;

    assign is_match = float_eq(i_sample, i_empty_value);
    assign closing  = !i_state.in_empty_run &&
                      (((i_req == REQ_SAMPLE) && is_match) || (i_req == REQ_EMPTY_RUN));
    assign opening  = i_state.in_empty_run && (i_req == REQ_SAMPLE) && !is_match;

    // a run that ends or begins restarts its count
    assign rc_base  = (closing || opening) ? '0 : i_state.run_count;
    assign rc_inc   = (i_req == REQ_EMPTY_RUN) ? WORD_W'(i_run_length) : WORD_W'(1);
    assign rc_next  = sat_add(rc_base, rc_inc);

    assign next_p1  = sat_add(i_state.next_addr, WORD_W'(1));
    assign next_p2  = sat_add(i_state.next_addr, WORD_W'(2));
    assign hdr_ext  = {1'b0, i_state.header_addr};
    assign hdr_p1   = hdr_ext + (WORD_W + 1)'(1);
    assign nx_ext   = {1'b0, i_state.next_addr};
    assign total    = ({1'b0, next_p2} > BUF_LIMIT) ? TOTAL_LIMIT : next_p2[TOTAL_W-1:0];

    always_comb begin
        logic [WORD_W:0] end_ext;
        end_ext       = {1'b0, next_p2};
        o_state       = i_state;
        o_batch.count = '0;
        o_batch.res   = '0;
        unique case (i_req)
            REQ_START: begin
                o_state          = STATE_RESET;
                o_batch.res[0]   = make_result('0, i_empty_value, '0);
                o_batch.count    = CNT_W'(1);
            end
            REQ_SAMPLE: begin
                o_state.run_count = rc_next;
                if (is_match) begin
                    if (closing) begin
                        o_batch.res[0]        = make_result(hdr_p1, i_state.run_count, '0);
                        o_batch.count         = CNT_W'(1);
                        o_state.in_empty_run  = 1'b1;
                        o_state.header_addr   = i_state.next_addr;
                        o_state.next_addr     = next_p2;
                    end
                end else begin
                    if (opening) begin
                        o_batch.res[0] = make_result(hdr_ext, i_state.run_count, '0);
                        o_batch.res[1] = make_result(nx_ext, i_sample, '0);
                        o_batch.count  = CNT_W'(2);
                    end else begin
                        o_batch.res[0] = make_result(nx_ext, i_sample, '0);
                        o_batch.count  = CNT_W'(1);
                    end
                    o_state.in_empty_run = 1'b0;
                    o_state.next_addr    = next_p1;
                end
            end
            REQ_EMPTY_RUN: begin
                o_state.run_count = rc_next;
                if (closing) begin
                    o_batch.res[0]       = make_result(hdr_p1, i_state.run_count, '0);
                    o_batch.count        = CNT_W'(1);
                    o_state.in_empty_run = 1'b1;
                    o_state.header_addr  = i_state.next_addr;
                    o_state.next_addr    = next_p2;
                end
            end
            REQ_END: begin
                o_state.next_addr = next_p2;
                if (!i_state.in_empty_run) begin
                    o_batch.res[0] = make_result(hdr_p1, i_state.run_count, total);
                    o_batch.res[1] = make_result(end_ext - (WORD_W + 1)'(2), '0, total);
                    o_batch.res[2] = make_result(end_ext - (WORD_W + 1)'(1), '0, total);
                    o_batch.count  = CNT_W'(3);
                end else begin
                    o_batch.res[0] = make_result(hdr_ext, i_state.run_count, total);
                    o_batch.res[1] = make_result(hdr_p1, '0, total);
                    o_batch.res[2] = make_result(end_ext - (WORD_W + 1)'(2), '0, total);
                    o_batch.res[3] = make_result(end_ext - (WORD_W + 1)'(1), '0, total);
                    o_batch.count  = CNT_W'(4);
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/sre_result_queue.sv
// ----------------------------------------------------------------------------
// sre_result_queue
// result register bank: holds the writes of one request and hands them
// out one per transaction, last one flagged
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sre_result_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sre_pkg::t_batch  i_batch,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_ready,
    output sre_pkg::t_result o_result,
    output logic             o_last
);
    import sre_pkg::*;

    t_result [MAX_RESULTS-1:0] r_bank;
    logic [CNT_W-1:0]          r_pending;
    logic [CNT_W-1:0]          n_pending;
    logic [IDX_W-1:0]          r_idx;
    logic [IDX_W-1:0]          n_idx;
    logic                      pop;

    assign o_valid  = (r_pending != '0);
    assign o_last   = (r_pending == CNT_W'(1));
    assign o_result = r_bank[r_idx];
    assign pop      = o_valid && i_ready;
    // bank frees up as its final result leaves
    assign o_free   = !o_valid || (o_last && i_ready);

    always_comb begin
        n_pending = r_pending;
        n_idx     = r_idx;
        if (i_push) begin
            n_pending = i_batch.count;
            n_idx     = '0;
        end else if (pop) begin
            n_pending = r_pending - CNT_W'(1);
            n_idx     = r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_idx     <= '0;
        end else begin
            r_pending <= n_pending;
            r_idx     <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_bank <= i_batch.res;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sparse_run_length_encoder_unit.sv
// ----------------------------------------------------------------------------
// sparse_run_length_encoder_unit
// turns float32 samples into write commands for a compressed buffer of
// empty-run / data-run header pairs followed by the stored samples
// ----------------------------------------------------------------------------
//  channel   dir  tdata                                   tuser / tlast
//  s_axis    in   sample, run_length                      req_type / -
//  m_axis    out  addr, data, wr valid, overflow, total   - / last of request
//  cfg       in   empty_value (i_cfg_wdata)               -
//
//  a request is taken while the result bank is free and its 0 to 4 writes
//  leave one per cycle from the result bank while m_axis is ready, the first
//  one the cycle after the request is taken; the next request is taken as
//  the last write leaves: start gives 1 write, sample 0 to 2, empty run 0 or
//  1, end 3 or 4; reset empties the result bank and sets the state as
//  after start; a stall on m_axis holds the bank and back-pressures s_axis
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sparse_run_length_encoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // sample[31:0], run_length[47:32]
    input  logic [1:0]  i_s_tuser,   // req_type[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // write_addr[15:0], write_data[47:16], write_valid[48], overflow[49],
    // total_words[66:50], zero[71:67]
    output logic [71:0] o_m_tdata,
    output logic        o_m_tlast
);
    import sre_pkg::*;

    t_state             r_state;
    t_state             n_state;
    logic [WORD_W-1:0]  r_empty_value;
    t_batch             batch;
    t_result            cur;
    logic               push;

    assign push = i_s_tvalid && o_s_tready;

    sre_step_logic u_step (
        .i_state       (r_state),
        .i_empty_value (r_empty_value),
        .i_req         (t_req'(i_s_tuser)),
        .i_sample      (i_s_tdata[WORD_W-1:0]),
        .i_run_length  (i_s_tdata[WORD_W+LEN_W-1:WORD_W]),
        .o_state       (n_state),
        .o_batch       (batch)
    );

    sre_result_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_batch  (batch),
        .o_free   (o_s_tready),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (cur),
        .o_last   (o_m_tlast)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= STATE_RESET;
            r_empty_value <= '0;
        end else begin
            if (push) begin
                r_state <= n_state;
            end
            if (i_cfg_we) begin
                r_empty_value <= i_cfg_wdata;
            end
        end
    end

    assign o_m_tdata = {5'd0, cur.total_words, cur.overflow, cur.write_valid,
                        cur.write_data, cur.write_addr};

endmodule

`default_nettype wire

FILE: rtl/sre_checker.sv
// ----------------------------------------------------------------------------
// sre_checker
// port-level checks of the sparse run-length encoder, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sparse_run_length_encoder_unit_defines.svh"

module sre_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        o_s_tready,
    input  logic [1:0]  i_s_tuser,
    input  logic        o_m_tvalid,
    input  logic        i_m_tready,
    input  logic [71:0] o_m_tdata,
    input  logic        o_m_tlast
);
    import sre_pkg::*;

    logic start_taken;

    assign start_taken = i_s_tvalid && o_s_tready && (i_s_tuser == REQ_START);

    // a stalled transaction keeps its payload
    `SRE_ASSERT_NEXT(a_hold_payload, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, $stable(o_m_tdata) && $stable(o_m_tlast))

    // every write is either performed or flagged, never both
    `SRE_ASSERT_SAME(a_write_or_flag, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[48] ^ o_m_tdata[49])

    // a start request is answered by a single write to word 0
    `SRE_ASSERT_NEXT(a_start_word0, i_clk, i_rst_n, start_taken, o_m_tvalid && o_m_tlast && (o_m_tdata[15:0] == 16'd0) && o_m_tdata[48])

    // the reported length never exceeds the buffer
    `SRE_ASSERT_SAME(a_total_cap, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[66:50] <= TOTAL_LIMIT)

endmodule

bind sparse_run_length_encoder_unit sre_checker u_sre_checker (.*);

`default_nettype wire

FILE: sim/tb_sparse_run_length_encoder_unit.sv
// ----------------------------------------------------------------------------
// tb_sparse_run_length_encoder_unit
// self-checking bench for the sparse run-length encoder: requests are queued
// per phase, driven on the input stream with random gaps, and every write
// leaving the block is compared with an encoder model updated on acceptance
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sparse_run_length_encoder_unit;

    import sre_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 300;

    typedef struct {
        t_req        kind;
        logic [31:0] sample;
        logic [15:0] run_length;
    } t_req_item;

    typedef struct {
        t_result res;
        logic    last;
    } t_write;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [31:0] i_cfg_wdata = '0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [47:0] i_s_tdata   = '0;  // sample[31:0], run_length[47:32]
    logic [1:0]  i_s_tuser   = '0;  // req_type[1:0]
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    // write_addr[15:0], write_data[47:16], write_valid[48], overflow[49],
    // total_words[66:50], zero[71:67]
    logic [71:0] o_m_tdata;
    logic        o_m_tlast;

    sparse_run_length_encoder_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // request queue, expected writes and encoder model state
    t_req_item   req_q[$];
    t_write      exp_writes[$];
    t_write      staged[$];
    t_req_item   drv_item;
    logic [31:0] empty_pattern = '0;
    logic        enc_in_empty  = 1'b1;
    logic [31:0] enc_run_cnt   = '0;
    logic [31:0] enc_hdr_addr  = 32'd1;
    logic [31:0] enc_next_addr = 32'd3;

    logic idle_on        = 1'b1;
    logic long_hold_arm  = 1'b0;
    logic long_hold_done = 1'b0;
    int   src_gap        = 0;
    int   snk_gap        = 0;
    int   stuck_cycles   = 0;
    int   reqs_pushed    = 0;
    int   reqs_sent      = 0;
    int   frames_started = 0;
    int   writes_seen    = 0;
    int   err_cnt        = 0;

    function automatic logic [31:0] add_clamp(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    // float compare against the empty pattern: signed zeros match, nan never
    function automatic logic is_empty_sample(input logic [31:0] s);
        logic s_nan;
        logic e_nan;
        s_nan = (s[30:23] == 8'hFF) && (s[22:0] != 0);
        e_nan = (empty_pattern[30:23] == 8'hFF) && (empty_pattern[22:0] != 0);
        if (s_nan || e_nan)
            return 1'b0;
        if (s[30:0] == 0 && empty_pattern[30:0] == 0)
            return 1'b1;
        return s == empty_pattern;
    endfunction

    function automatic void stage_write(input logic [32:0] addr, input logic [31:0] data,
                                        input logic [16:0] total);
        t_write w;
        w.res.overflow    = (addr >= 33'(BUF_WORDS));
        w.res.write_valid = !w.res.overflow;
        w.res.write_addr  = addr[15:0];
        w.res.write_data  = data;
        w.res.total_words = total;
        w.last            = 1'b0;
        staged.push_back(w);
    endfunction

    function automatic void close_data_run();
        stage_write({1'b0, enc_hdr_addr} + 33'd1, enc_run_cnt, '0);
        enc_run_cnt   = '0;
        enc_in_empty  = 1'b1;
        enc_hdr_addr  = enc_next_addr;
        enc_next_addr = add_clamp(enc_next_addr, 32'd2);
    endfunction

    // advance the encoder model by one request and queue the writes it causes
    function automatic void encode_request(input t_req_item rq);
        logic [16:0] total;
        t_write      w;
        staged.delete();
        case (rq.kind)
            REQ_START: begin
                enc_in_empty  = 1'b1;
                enc_run_cnt   = '0;
                enc_hdr_addr  = 32'd1;
                enc_next_addr = 32'd3;
                frames_started++;
                stage_write(33'd0, empty_pattern, '0);
            end
            REQ_SAMPLE: begin
                if (is_empty_sample(rq.sample)) begin
                    if (!enc_in_empty)
                        close_data_run();
                end else begin
                    if (enc_in_empty) begin
                        stage_write({1'b0, enc_hdr_addr}, enc_run_cnt, '0);
                        enc_run_cnt  = '0;
                        enc_in_empty = 1'b0;
                    end
                    stage_write({1'b0, enc_next_addr}, rq.sample, '0);
                    enc_next_addr = add_clamp(enc_next_addr, 32'd1);
                end
                enc_run_cnt = add_clamp(enc_run_cnt, 32'd1);
            end
            REQ_EMPTY_RUN: begin
                if (!enc_in_empty)
                    close_data_run();
                enc_run_cnt = add_clamp(enc_run_cnt, {16'd0, rq.run_length});
            end
            default: begin
                enc_next_addr = add_clamp(enc_next_addr, 32'd2);
                total = (enc_next_addr > BUF_WORDS) ? 17'(BUF_WORDS) : enc_next_addr[16:0];
                if (!enc_in_empty) begin
                    stage_write({1'b0, enc_hdr_addr} + 33'd1, enc_run_cnt, total);
                end else begin
                    stage_write({1'b0, enc_hdr_addr}, enc_run_cnt, total);
                    stage_write({1'b0, enc_hdr_addr} + 33'd1, '0, total);
                end
                stage_write({1'b0, enc_next_addr} - 33'd2, '0, total);
                stage_write({1'b0, enc_next_addr} - 33'd1, '0, total);
            end
        endcase
        for (int i = 0; i < staged.size(); i++) begin
            w      = staged[i];
            w.last = (i == staged.size() - 1);
            exp_writes.push_back(w);
        end
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            err_cnt++;
        end
    endfunction

    // input side
    always @(posedge i_clk) begin
        logic offer;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            src_gap    = 0;
        end else begin
            offer = 1'b0;
            if (i_s_tvalid && o_s_tready) begin
                encode_request(drv_item);
                reqs_sent++;
            end
            if (i_s_tvalid && !o_s_tready) begin
                offer = 1'b1;
            end else if (src_gap > 0) begin
                src_gap--;
            end else if (req_q.size() > 0) begin
                if (idle_on && $urandom_range(0, 5) == 0) begin
                    src_gap = $urandom_range(0, 18);
                end else begin
                    drv_item = req_q.pop_front();
                    offer    = 1'b1;
                end
            end
            i_s_tvalid <= offer;
            if (offer) begin
                i_s_tdata <= {drv_item.run_length, drv_item.sample};
                i_s_tuser <= drv_item.kind;
            end
        end
    end

    // output side
    always @(posedge i_clk) begin
        t_result got;
        t_write  want;
        logic    rdy;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            snk_gap    = 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got = t_result'(o_m_tdata[66:0]);
                writes_seen++;
                if (exp_writes.size() == 0) begin
                    $display("%0t: write transaction with nothing expected, expected none actual %h",
                             $time, o_m_tdata);
                    err_cnt++;
                end else begin
                    want = exp_writes.pop_front();
                    compare_field("write_addr", 32'(want.res.write_addr), 32'(got.write_addr));
                    compare_field("write_data", want.res.write_data, got.write_data);
                    compare_field("write_valid", 32'(want.res.write_valid), 32'(got.write_valid));
                    compare_field("overflow", 32'(want.res.overflow), 32'(got.overflow));
                    compare_field("total_words", 32'(want.res.total_words),
                                  32'(got.total_words));
                    compare_field("last", 32'(want.last), 32'(o_m_tlast));
                end
            end
            // one long hold-off so the result bank fills and the input stalls
            if (long_hold_arm && !long_hold_done) begin
                snk_gap        = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            rdy = 1'b0;
            if (snk_gap > 0)
                snk_gap--;
            else if (idle_on && $urandom_range(0, 7) == 0)
                snk_gap = $urandom_range(0, 18);
            else
                rdy = 1'b1;
            i_m_tready <= rdy;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("sparse_run_length_encoder_unit test failed");
                $finish;
            end
        end
    end

    task automatic add_req(input t_req k, input logic [31:0] s, input logic [15:0] n);
        t_req_item r;
        r.kind       = k;
        r.sample     = s;
        r.run_length = n;
        req_q.push_back(r);
        reqs_pushed++;
    endtask

    task automatic wait_drained();
        while (reqs_sent != reqs_pushed || exp_writes.size() != 0)
            @(posedge i_clk);
        // a request with no writes may still be in the block
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_empty(input logic [31:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        empty_pattern = v;
    endtask

    // mostly well-formed frames with random content, some noise mixed in
    task automatic add_random_frame(input int n_ops);
        logic [31:0] s;
        logic [15:0] n;
        if ($urandom_range(0, 7) != 0)
            add_req(REQ_START, $urandom(), 16'($urandom()));
        for (int i = 0; i < n_ops; i++) begin
            s = $urandom();
            n = 16'($urandom());
            case ($urandom_range(0, 19))
                0, 1, 2, 3: add_req(REQ_SAMPLE, empty_pattern, n);
                4:          add_req(REQ_SAMPLE, {~empty_pattern[31], empty_pattern[30:0]}, n);
                5:          add_req(REQ_SAMPLE, {s[31], 8'hFF, s[22:0] | 23'd1}, n);
                6:          add_req(REQ_SAMPLE, {s[31], 31'd0}, n);
                12, 13, 14: add_req(REQ_EMPTY_RUN, s, 16'($urandom_range(0, 20)));
                15:         add_req(REQ_EMPTY_RUN, s, 16'hFFFF);
                16:         add_req(REQ_EMPTY_RUN, s, n);
                17:         add_req(REQ_START, s, n);
                18:         add_req(REQ_END, s, n);
                default:    add_req(REQ_SAMPLE, s, n);
            endcase
        end
        add_req(REQ_END, $urandom(), 16'($urandom()));
        if ($urandom_range(0, 7) == 0)
            add_req(REQ_END, $urandom(), 16'($urandom()));
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty value still at its reset value of zero
        add_req(REQ_END, 32'h0, 16'h0);             // end with no start
        add_req(REQ_START, 32'h0, 16'h0);
        add_req(REQ_SAMPLE, 32'h0000_0000, 16'h0);
        add_req(REQ_SAMPLE, 32'h8000_0000, 16'h0);  // negative zero is empty
        add_req(REQ_EMPTY_RUN, 32'h0, 16'hFFFF);
        add_req(REQ_SAMPLE, 32'h3F80_0000, 16'h0);
        add_req(REQ_SAMPLE, 32'h7FC0_0000, 16'h0);
        add_req(REQ_SAMPLE, 32'hFFFF_FFFF, 16'hFFFF);
        add_req(REQ_SAMPLE, 32'h7F80_0000, 16'h0);
        add_req(REQ_SAMPLE, 32'h0000_0001, 16'h0);
        add_req(REQ_EMPTY_RUN, 32'h0, 16'h0);       // zero-length run still closes
        add_req(REQ_EMPTY_RUN, 32'hFFFF_FFFF, 16'h1);
        add_req(REQ_SAMPLE, 32'hFF80_0000, 16'h0);
        add_req(REQ_SAMPLE, 32'h8000_0000, 16'h0);
        add_req(REQ_END, 32'h0, 16'h0);
        add_req(REQ_START, 32'h0, 16'h0);
        add_req(REQ_SAMPLE, 32'hAAAA_AAAA, 16'h5555);
        add_req(REQ_EMPTY_RUN, 32'h0, 16'hAAAA);
        add_req(REQ_SAMPLE, 32'h5555_5555, 16'hAAAA);
        add_req(REQ_END, 32'h0, 16'h0);
        add_req(REQ_START, 32'h0, 16'h0);
        add_req(REQ_SAMPLE, 32'h1234_5678, 16'h0);
        add_req(REQ_START, 32'h0, 16'h0);           // restart inside a frame
        add_req(REQ_END, 32'h0, 16'h0);
        wait_drained();

        write_empty(32'hFFFF_FFFF);
        long_hold_arm <= 1'b1;
        repeat (2) add_random_frame(20);
        wait_drained();

        write_empty(32'h8000_0000);
        repeat (2) add_random_frame(20);
        wait_drained();

        // a nan pattern never matches, so every sample is stored
        write_empty(32'h7FC0_0000);
        repeat (2) add_random_frame(20);
        wait_drained();

        write_empty($urandom());
        repeat (2) add_random_frame(20);
        wait_drained();

        // no idling: a short frame driven back to back
        write_empty(32'h0000_0000);
        idle_on <= 1'b0;
        add_req(REQ_START, 32'h0, 16'h0);
        for (int i = 0; i < 6; i++)
            add_req(REQ_SAMPLE, $urandom() | 32'h1, 16'($urandom()));
        add_req(REQ_SAMPLE, 32'h8000_0000, 16'h0);
        add_req(REQ_EMPTY_RUN, $urandom(), 16'hFFFF);
        add_req(REQ_EMPTY_RUN, $urandom(), 16'hFFFF);
        add_req(REQ_SAMPLE, 32'h4049_0FDB, 16'h0);
        add_req(REQ_END, 32'h0, 16'h0);
        wait_drained();
        repeat (16) @(posedge i_clk);

        $display("covered %0d requests in %0d frames over six empty values, with a long output stall",
                 reqs_sent, frames_started);
        $display("and a closing burst with no idling: %0d writes checked", writes_seen);
        if (err_cnt == 0 && exp_writes.size() == 0)
            $display("sparse_run_length_encoder_unit test passed");
        else
            $display("sparse_run_length_encoder_unit test failed");
        $finish;
    end

endmodule

FILE: sparse_run_length_encoder_unit.f
+incdir+rtl
rtl/sre_pkg.sv
rtl/sre_step_logic.sv
rtl/sre_result_queue.sv
rtl/sparse_run_length_encoder_unit.sv
rtl/sre_checker.sv
sim/tb_sparse_run_length_encoder_unit.sv
